### src/plist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_pkg : shared types and constants of the positional list
// Beat payloads, opcode and status codes, cell control, and the constant
// functions that size the read-out OR tree.
// ----------------------------------------------------------------------------
package plist_pkg;

	localparam int VALUE_W  = 32;
	localparam int POS_W    = 7;
	localparam int OPCODE_W = 2;
	localparam int STATUS_W = 2;
	localparam int RADIX    = 8;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// input beat
	typedef struct packed {
		logic [OPCODE_W-1:0]       opcode;
		logic [POS_W-1:0]          position;
		logic signed [VALUE_W-1:0] value;
	} in_t;

	// result beat
	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [VALUE_W-1:0] read_value;
		logic [POS_W-1:0]          count;
	} out_t;

	// shift command broadcast to every cell
	typedef struct packed {
		logic                      ins;
		logic                      del;
		logic [POS_W-1:0]          pos;
		logic signed [VALUE_W-1:0] value;
	} cell_ctl_t;

	// node count of tree level l over n leaves (level 0 = leaves)
	function automatic int level_size(int n, int l);
		int s;
		s = n;
		for (int i = 0; i < l; i++)
			s = (s + RADIX - 1) / RADIX;
		return s;
	endfunction

	// number of registered reduction levels above the leaves
	function automatic int tree_depth(int n);
		int d;
		int s;
		d = 0;
		s = n;
		while (s > 1) begin
			s = (s + RADIX - 1) / RADIX;
			d++;
		end
		return d;
	endfunction

	// offset of level l (l >= 1) in the flat node store
	function automatic int level_base(int n, int l);
		int b;
		b = 0;
		for (int i = 1; i < l; i++)
			b += level_size(n, i);
		return b;
	endfunction

endpackage

### src/plist_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_cell : one list slot
// Holds one entry; on insert takes its left neighbor or the new value, on
// delete takes its right neighbor. Also registers its entry as a tree leaf
// when it is the slot being read.
// ----------------------------------------------------------------------------
module plist_cell import plist_pkg::*; #(
	parameter int INDEX = 0
) (
	input  logic                      clk,
	input  cell_ctl_t                 ctl,
	input  logic [POS_W-1:0]          rd_pos,
	input  logic signed [VALUE_W-1:0] left,
	input  logic signed [VALUE_W-1:0] right,
	output logic signed [VALUE_W-1:0] entry,
	output logic signed [VALUE_W-1:0] leaf
);

	localparam int IDX_W = $clog2(INDEX + 2);
	localparam int XW    = (POS_W > IDX_W) ? POS_W + 1 : IDX_W + 1;
	localparam logic [XW-1:0] IDX_X = XW'(INDEX);

	logic signed [VALUE_W-1:0] entry_q;
	logic signed [VALUE_W-1:0] leaf_q;
	logic [XW-1:0]             pos_x;
	logic [XW-1:0]             rd_x;

	assign pos_x = XW'(ctl.pos);
	assign rd_x  = XW'(rd_pos);

	// shift / place
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (IDX_X == pos_x)
				entry_q <= ctl.value;
			else if (IDX_X > pos_x)
				entry_q <= left;
		end else if (ctl.del) begin
			if (IDX_X >= pos_x)
				entry_q <= right;
		end
	end

	// masked leaf for the read-out tree
	always_ff @(posedge clk) begin
		leaf_q <= (IDX_X == rd_x) ? entry_q : '0;
	end

	assign entry = entry_q;
	assign leaf  = leaf_q;

endmodule

### src/plist_or_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_or_tree : registered OR reduction of the cell leaves
// Radix-8 tree, one register level per stage. At most one leaf is nonzero,
// so the root carries the selected entry once it has passed every level.
// ----------------------------------------------------------------------------
module plist_or_tree import plist_pkg::*; #(
	parameter int N = 64
) (
	input  logic                      clk,
	input  logic signed [VALUE_W-1:0] leaves [N],
	output logic signed [VALUE_W-1:0] root
);

	localparam int DEPTH = tree_depth(N);
	localparam int TOTAL = level_base(N, DEPTH + 1);

	logic signed [VALUE_W-1:0] nodes_q [TOTAL];

	for (genvar l = 1; l <= DEPTH; l++) begin : g_lvl
		for (genvar j = 0; j < level_size(N, l); j++) begin : g_node
			logic signed [VALUE_W-1:0] kid [RADIX];
			logic signed [VALUE_W-1:0] sum;

			// pick children from the level below
			for (genvar i = 0; i < RADIX; i++) begin : g_kid
				if (j * RADIX + i < level_size(N, l - 1)) begin : g_live
					if (l == 1) begin : g_leaf
						assign kid[i] = leaves[j * RADIX + i];
					end else begin : g_inner
						assign kid[i] = nodes_q[level_base(N, l - 1) + j * RADIX + i];
					end
				end else begin : g_pad
					assign kid[i] = '0;
				end
			end

			always_comb begin
				sum = '0;
				for (int i = 0; i < RADIX; i++)
					sum = sum | kid[i];
			end

			always_ff @(posedge clk) begin
				nodes_q[level_base(N, l) + j] <= sum;
			end
		end
	end

	assign root = nodes_q[level_base(N, DEPTH)];

endmodule

### src/positional_list_insert_delete_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top : ordered list with positional edits
// Row of CAPACITY cells that shift together on insert and delete, plus a
// registered OR tree that reads one slot out.
//
//   channel   handshake               payload
//   --------  ----------------------  ---------------------------------
//   command   start && !busy          item   (opcode, position, value)
//   result    done, one cycle         result (status, read_value, count)
//
// Insert, delete, refused and unused-opcode beats: result in the cycle after
// the command, and a new command is taken in the very next cycle.
// An in-range read holds busy while the read position register, the leaf
// register and the radix-8 OR tree levels fill; done rises as busy drops.
// arst_n clears the count, busy and done; cell contents are not reset.
// The receiver cannot stall: done is high for exactly one cycle per beat.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_top import plist_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  item,
	output logic done,
	output out_t result
);

	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (CW > POS_W) ? CW + 1 : POS_W + 1;
	localparam int DEPTH  = tree_depth(CAPACITY);
	localparam int WAIT   = DEPTH + 1;
	localparam int WAIT_W = $clog2(WAIT + 1);

	logic [CW-1:0]             count_q;
	logic                      busy_q;
	logic                      done_q;
	logic [WAIT_W-1:0]         wait_q;
	logic [POS_W-1:0]          rd_pos_q;
	out_t                      res_q;

	logic                      accept;
	logic [CMP_W-1:0]          pos_x;
	logic [CMP_W-1:0]          cnt_x;
	logic                      ins_ok;
	logic                      del_ok;
	logic                      rd_ok;
	status_t                   status_now;
	logic [CW-1:0]             count_next;
	cell_ctl_t                 ctl;

	logic signed [VALUE_W-1:0] ent    [CAPACITY];
	logic signed [VALUE_W-1:0] leaves [CAPACITY];
	logic signed [VALUE_W-1:0] root;

	assign accept = start && !busy_q;
	assign pos_x  = CMP_W'(item.position);
	assign cnt_x  = CMP_W'(count_q);

	// command decode and range checks
	always_comb begin
		ins_ok     = 1'b0;
		del_ok     = 1'b0;
		rd_ok      = 1'b0;
		status_now = ST_DONE;
		unique case (opcode_t'(item.opcode))
			OP_INSERT: begin
				if (pos_x > cnt_x)
					status_now = ST_RANGE;
				else if (cnt_x == CMP_W'(CAPACITY))
					status_now = ST_FULL;
				else
					ins_ok = 1'b1;
			end
			OP_DELETE: begin
				if (pos_x >= cnt_x)
					status_now = ST_RANGE;
				else
					del_ok = 1'b1;
			end
			OP_READ: begin
				if (pos_x >= cnt_x)
					status_now = ST_RANGE;
				else
					rd_ok = 1'b1;
			end
			default: status_now = ST_DONE;
		endcase
	end

	always_comb begin
		count_next = count_q;
		if (ins_ok)
			count_next = count_q + CW'(1);
		else if (del_ok)
			count_next = count_q - CW'(1);
	end

	// shift command to the row
	assign ctl.ins   = accept && ins_ok;
	assign ctl.del   = accept && del_ok;
	assign ctl.pos   = item.position;
	assign ctl.value = item.value;

	// row of cells
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic signed [VALUE_W-1:0] lft;
		logic signed [VALUE_W-1:0] rgt;

		if (k == 0) begin : g_first
			assign lft = '0;
		end else begin : g_mid_l
			assign lft = ent[k - 1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign rgt = '0;
		end else begin : g_mid_r
			assign rgt = ent[k + 1];
		end

		plist_cell #(
			.INDEX(k)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.rd_pos(rd_pos_q),
			.left  (lft),
			.right (rgt),
			.entry (ent[k]),
			.leaf  (leaves[k])
		);
	end

	// read-out tree
	plist_or_tree #(
		.N(CAPACITY)
	) u_tree (
		.clk   (clk),
		.leaves(leaves),
		.root  (root)
	);

	// control: count, busy, read wait, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			wait_q  <= '0;
		end else if (busy_q) begin
			if (wait_q != '0) begin
				wait_q <= wait_q - WAIT_W'(1);
				done_q <= 1'b0;
			end else begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else if (accept) begin
			count_q <= count_next;
			if (rd_ok) begin
				busy_q <= 1'b1;
				wait_q <= WAIT_W'(WAIT);
				done_q <= 1'b0;
			end else begin
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// result and read position
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (wait_q == '0) begin
				res_q.status     <= ST_DONE;
				res_q.read_value <= root;
				res_q.count      <= POS_W'(count_q);
			end
		end else if (accept) begin
			rd_pos_q         <= item.position;
			res_q.status     <= status_now;
			res_q.read_value <= '0;
			res_q.count      <= POS_W'(count_next);
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = res_q;

endmodule

### src/plist_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_checker : port-level checks for the positional list
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module plist_checker import plist_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input in_t  item,
	input logic done,
	input out_t result
);

	localparam logic [POS_W-1:0] CAP_P = POS_W'(CAPACITY);

	// non-read commands answer on the next beat
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.opcode != OP_READ) |=> (done && !busy))
		else $error("command without read did not answer next cycle");

	// no result while a read is still in the tree
	a_busy_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result strobe while busy");

	// refused beats (any status other than done) carry a zero word
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_DONE) |-> (result.read_value == '0))
		else $error("refused beat carries a nonzero read value");

	// full refusal only at capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_FULL) |-> (result.count == CAP_P))
		else $error("list-full status with count below capacity");

	// count moves by at most one between results on consecutive cycles
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done)) |->
			(result.count == $past(result.count) ||
			 result.count == $past(result.count) + POS_W'(1) ||
			 result.count == $past(result.count) - POS_W'(1)))
		else $error("count jumped by more than one");

endmodule

bind positional_list_insert_delete_top plist_checker #(
	.CAPACITY(CAPACITY)
) u_plist_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.item  (item),
	.done  (done),
	.result(result)
);
